>>> hw/rtl/mmb_pkg.sv
// ----------------------------------------------------------------------------
// mmb_pkg: shared types, constants and status decode for the MIDI batcher
// Holds field widths, register indexes, status byte codes and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mmb_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int MSG_LIMIT_W = 7;
  localparam int SYSEX_W     = 10;
  localparam int LEN_OUT_W   = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  // Default buffer depth
  localparam int DEFAULT_BUFFER_DEPTH = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYSEX_DATA_LIMIT = 1'b1;

  // Register reset values
  localparam logic [MSG_LIMIT_W-1:0] MESSAGE_LIMIT_RST    = 7'd16;
  localparam logic [SYSEX_W-1:0]     SYSEX_DATA_LIMIT_RST = 10'd128;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // Tally saturation
  localparam logic [MSG_LIMIT_W-1:0] TALLY_MAX = 7'd127;

  // Status byte codes
  localparam logic [BYTE_W-1:0] ST_SYSTEM_FIRST = 8'hF0;
  localparam logic [BYTE_W-1:0] ST_SYSEX        = 8'hF0;
  localparam logic [BYTE_W-1:0] ST_MTC_QFRAME   = 8'hF1;
  localparam logic [BYTE_W-1:0] ST_SONG_POS     = 8'hF2;
  localparam logic [BYTE_W-1:0] ST_SONG_SELECT  = 8'hF3;
  localparam logic [BYTE_W-1:0] ST_UNDEF_F4     = 8'hF4;
  localparam logic [BYTE_W-1:0] ST_UNDEF_F5     = 8'hF5;
  localparam logic [BYTE_W-1:0] ST_UNDEF_F9     = 8'hF9;
  localparam logic [BYTE_W-1:0] ST_UNDEF_FD     = 8'hFD;
  localparam logic [3:0]        ST_PROG_CHANGE  = 4'hC;
  localparam logic [3:0]        ST_CHAN_PRESS   = 4'hD;

  localparam logic [SYSEX_W:0]  SYSEX_EXTRA     = 11'd3;
  localparam logic [SYSEX_W-1:0] SYSEX_SAT      = 10'd1023;

  // Decoded status byte
  typedef struct packed {
    logic               drop;
    logic [SYSEX_W-1:0] count;
  } status_info_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // apply the accepted transaction
    logic start;  // begin batch readout at entry 0
    logic step;   // advance readout index
    logic clear;  // batch done: clear length, tally, open flag
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_req;   // current transaction closes the batch
    logic last_item;  // readout index is on the final result
  } dp_stat_t;

  // Expected data count for a status byte, or drop
  function automatic status_info_t status_decode(input logic [BYTE_W-1:0]  b,
                                                 input logic [SYSEX_W-1:0] sysex_limit);
    status_info_t     info;
    logic [SYSEX_W:0] s;
    info.drop  = 1'b0;
    info.count = '0;
    s = {1'b0, sysex_limit} + SYSEX_EXTRA;
    if (b < ST_SYSTEM_FIRST) begin
      case (b[7:4])
        ST_PROG_CHANGE, ST_CHAN_PRESS: info.count = 10'd1;
        default:                       info.count = 10'd2;
      endcase
    end else begin
      case (b)
        ST_SYSEX:                      info.count = s[SYSEX_W] ? SYSEX_SAT : s[SYSEX_W-1:0];
        ST_MTC_QFRAME, ST_SONG_SELECT: info.count = 10'd1;
        ST_SONG_POS:                   info.count = 10'd2;
        ST_UNDEF_F4, ST_UNDEF_F5,
        ST_UNDEF_F9, ST_UNDEF_FD:      info.drop  = 1'b1;
        default:                       info.count = '0;
      endcase
    end
    return info;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/midi_message_batcher.sv
// ----------------------------------------------------------------------------
// midi_message_batcher: MIDI byte parser and message batcher
// Gathers kept MIDI message bytes into a buffer and emits them as a batch.
//
//   channel  dir  handshake              payload
//   input    in   in_valid / in_stall    command, rx_byte
//   result   out  out_valid / out_stall  out_byte, byte_valid, batch_length, last
//   config   in   cfg_write              cfg_index, cfg_data
//
// A transaction that closes no batch leaves the controller idle. A closing one
// then streams the batch: each result takes a buffer RAM read, then a show,
// and the show holds while the output stalls; an empty batch shows one result.
// Reset is synchronous; it clears the parser state and loads register defaults.
// Input is stalled for the whole readout; a stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_batcher import mmb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  command,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [BYTE_W-1:0]          out_byte,
  output logic                       byte_valid,
  output logic [LEN_OUT_W-1:0]       batch_length,
  output logic                       last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mmb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmb_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .batch_length (batch_length)
  );

  // Final result flag of the batch
  assign last = stat.last_item;

endmodule

`default_nettype wire

>>> hw/rtl/mmb_ram.sv
// ----------------------------------------------------------------------------
// mmb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/mmb_datapath.sv
// ----------------------------------------------------------------------------
// mmb_datapath: message parsing state, batch buffer and readout
// Tracks expected data count, message tally and stored length, writes kept
// bytes into the buffer RAM and walks it on command during emission.
// ----------------------------------------------------------------------------
`default_nettype none

module mmb_datapath import mmb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  command,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic [BYTE_W-1:0]          out_byte,
  output logic                       byte_valid,
  output logic [LEN_OUT_W-1:0]       batch_length
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int LW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_LEN = LW'(BUFFER_DEPTH);

  // Configuration registers
  logic [MSG_LIMIT_W-1:0] message_limit;
  logic [SYSEX_W-1:0]     sysex_data_limit;

  // Parser state
  logic [LW-1:0]          stored_length;
  logic [MSG_LIMIT_W-1:0] message_tally;
  logic [SYSEX_W-1:0]     expected_data;
  logic                   batch_open;
  logic [AW-1:0]          rd_idx;

  // Next-value terms for a received byte
  status_info_t           info;
  logic                   is_status;
  logic                   keep;
  logic                   room;
  logic [SYSEX_W-1:0]     expected_next;
  logic [LW-1:0]          length_next;
  logic [MSG_LIMIT_W-1:0] tally_next;
  logic                   byte_emit;
  logic                   idle_emit;
  logic [BYTE_W-1:0]      ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_limit    <= MESSAGE_LIMIT_RST;
      sysex_data_limit <= SYSEX_DATA_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MESSAGE_LIMIT:    message_limit    <= cfg_data[MSG_LIMIT_W-1:0];
        REG_SYSEX_DATA_LIMIT: sysex_data_limit <= cfg_data[SYSEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte decode and next state
  always_comb begin
    info      = status_decode(rx_byte, sysex_data_limit);
    is_status = rx_byte[BYTE_W-1];
    room      = (stored_length < DEPTH_LEN);
    keep      = is_status ? !info.drop : (expected_data != '0);
    if (is_status && !info.drop) begin
      expected_next = info.count;
    end else if (!is_status && expected_data != '0) begin
      expected_next = expected_data - 1'b1;
    end else begin
      expected_next = expected_data;
    end
    length_next = (keep && room) ? stored_length + 1'b1 : stored_length;
    tally_next  = (expected_next == '0 && message_tally < TALLY_MAX) ?
                  message_tally + 1'b1 : message_tally;
    byte_emit   = (length_next >= DEPTH_LEN) || (tally_next >= message_limit);
    idle_emit   = batch_open && (expected_data == '0);
  end

  assign stat.emit_req  = (command == CMD_IDLE) ? idle_emit : byte_emit;
  assign stat.last_item = (stored_length == '0) || (LW'(rd_idx) + 1'b1 == stored_length);

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_length <= '0;
      message_tally <= '0;
      expected_data <= '0;
      batch_open    <= 1'b0;
    end else if (cmd.clear) begin
      stored_length <= '0;
      message_tally <= '0;
      batch_open    <= 1'b0;
    end else if (cmd.take && command == CMD_BYTE) begin
      stored_length <= length_next;
      message_tally <= tally_next;
      expected_data <= expected_next;
      batch_open    <= 1'b1;
    end
  end

  // Readout index
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      rd_idx <= '0;
    end else if (cmd.step) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  mmb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take && command == CMD_BYTE && keep && room),
    .waddr (stored_length[AW-1:0]),
    .wdata (rx_byte),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Result fields; an empty batch shows a zero byte
  assign byte_valid   = (stored_length != '0);
  assign out_byte     = byte_valid ? ram_rdata : '0;
  assign batch_length = LEN_OUT_W'(stored_length);

  // Buffer never overfills
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    stored_length <= DEPTH_LEN)
    else $error("stored length beyond buffer depth");

endmodule

`default_nettype wire

>>> hw/rtl/mmb_ctrl.sv
// ----------------------------------------------------------------------------
// mmb_ctrl: batcher controller
// Accepts one transaction at a time; after one that closes a batch it walks
// the batch out one result per read/show pair before returning to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmb_ctrl import mmb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_take;
  logic       out_take;

  assign in_stall  = rst || (state != S_IDLE);
  assign out_valid = (state == S_SHOW);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd.take = 1'b1;
          if (stat.emit_req) begin
            cmd.start  = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_SHOW;
      S_SHOW: begin
        if (out_take) begin
          if (stat.last_item) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_read_show: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_SHOW)
    else $error("read not followed by show");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_take && stat.last_item) |=> (state == S_IDLE && !out_valid))
    else $error("batch did not close after last result");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during batch readout");

endmodule

`default_nettype wire
